// ----- rtl/rth_pkg.sv -----
// Shared types, constants and the restoring-division step for the RGB to HSV converter.
// Used by every module of the rgb_to_hsv_convert block; depends on nothing else.
package rth_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned ACC_W     = 2 * PIX_W;
    localparam int unsigned NUM_CELLS = PIX_W;

    localparam logic [PIX_W-1:0] HUE_BASE_RED   = 8'd0;
    localparam logic [PIX_W-1:0] HUE_BASE_GREEN = 8'd85;
    localparam logic [PIX_W-1:0] HUE_BASE_BLUE  = 8'd171;
    localparam logic [PIX_W-1:0] SAT_SCALE      = 8'd255;
    localparam logic [PIX_W-1:0] HUE_SCALE      = 8'd43;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [PIX_W-1:0] divisor;
    } rth_lane_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [PIX_W-1:0] base;
        logic             neg;
        logic             grey;
    } rth_side_t;

    typedef struct packed {
        rth_lane_t sat;
        rth_lane_t hue;
        rth_side_t side;
    } rth_cell_t;

    // One quotient bit of a restoring division whose quotient fits in PIX_W bits.
    function automatic rth_lane_t rth_div_step(input rth_lane_t lane);
        rth_lane_t        res;
        logic [PIX_W:0]   trial;
        logic [PIX_W:0]   diff;
        trial       = lane.acc[ACC_W-1:PIX_W-1];
        diff        = trial - {1'b0, lane.divisor};
        res.divisor = lane.divisor;
        if (trial >= {1'b0, lane.divisor})
        begin
            res.acc = {diff[PIX_W-1:0], lane.acc[PIX_W-2:0], 1'b1};
        end
        else
        begin
            res.acc = {lane.acc[ACC_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ----- rtl/rgb_to_hsv_convert.sv -----
// RGB to HSV converter, 8 bits per channel: front end, a chain of eight division cells, output stage.
// An accepted transaction passes two front-end stages, the division chain (one cell per quotient bit)
// and the output register. Throughput is one transaction per cycle while out_ready is high; every
// stage holds its own valid bit, so bubbles close up.
// Reset (rst_n, asynchronous, active low) empties all stages; payload registers are not reset.
module rgb_to_hsv_convert (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [rth_pkg::PIX_W-1:0] red_in,
    input  logic [rth_pkg::PIX_W-1:0] green_in,
    input  logic [rth_pkg::PIX_W-1:0] blue_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [rth_pkg::PIX_W-1:0] hue_out,
    output logic [rth_pkg::PIX_W-1:0] saturation_out,
    output logic [rth_pkg::PIX_W-1:0] value_out
);

    logic               cell_valid [rth_pkg::NUM_CELLS+1];
    logic               cell_ready [rth_pkg::NUM_CELLS+1];
    rth_pkg::rth_cell_t cell_data  [rth_pkg::NUM_CELLS+1];

    rth_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .valid    (cell_valid[0]),
        .data     (cell_data[0]),
        .ready    (cell_ready[0])
    );

    for (genvar i = 0; i < rth_pkg::NUM_CELLS; i++)
    begin : g_cell
        rth_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (cell_valid[i]),
            .in_ready (cell_ready[i]),
            .in_data  (cell_data[i]),
            .valid    (cell_valid[i+1]),
            .data     (cell_data[i+1]),
            .ready    (cell_ready[i+1])
        );
    end

    rth_finish u_finish (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (cell_valid[rth_pkg::NUM_CELLS]),
        .in_ready       (cell_ready[rth_pkg::NUM_CELLS]),
        .in_data        (cell_data[rth_pkg::NUM_CELLS]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hue_out        (hue_out),
        .saturation_out (saturation_out),
        .value_out      (value_out)
    );

    a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_out == '0 |-> saturation_out == '0 && hue_out == '0)
        else $error("black pixel produced nonzero hue or saturation");

    a_grey_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturation_out == '0 |-> hue_out == '0)
        else $error("zero saturation with nonzero hue");

    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[0] && !cell_ready[0] |=> cell_valid[0] && $stable(cell_data[0]))
        else $error("front-end transaction lost while the division chain stalled");

endmodule

// ----- rtl/rth_prep.sv -----
// Front end of the converter: finds max, min and the hue difference, then scales the dividends.
// Two register stages; depends on rth_pkg.
module rth_prep (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [rth_pkg::PIX_W-1:0] red_in,
    input  logic [rth_pkg::PIX_W-1:0] green_in,
    input  logic [rth_pkg::PIX_W-1:0] blue_in,
    output logic                     valid,
    output rth_pkg::rth_cell_t       data,
    input  logic                     ready
);

    logic                      s1_valid_reg;
    logic [rth_pkg::PIX_W-1:0] s1_value_reg;
    logic [rth_pkg::PIX_W-1:0] s1_span_reg;
    logic [rth_pkg::PIX_W-1:0] s1_mag_reg;
    logic [rth_pkg::PIX_W-1:0] s1_base_reg;
    logic                      s1_neg_reg;
    logic                      s1_grey_reg;

    logic [rth_pkg::PIX_W-1:0] s1_value_next;
    logic [rth_pkg::PIX_W-1:0] s1_span_next;
    logic [rth_pkg::PIX_W-1:0] s1_mag_next;
    logic [rth_pkg::PIX_W-1:0] s1_base_next;
    logic                      s1_neg_next;
    logic                      s1_grey_next;

    logic                      s2_valid_reg;
    rth_pkg::rth_cell_t        s2_data_reg;
    rth_pkg::rth_cell_t        s2_data_next;

    logic                      s1_load;
    logic                      s2_load;

    logic [rth_pkg::PIX_W-1:0] hi;
    logic [rth_pkg::PIX_W-1:0] lo;
    logic [rth_pkg::PIX_W-1:0] opa;
    logic [rth_pkg::PIX_W-1:0] opb;

    assign s2_load  = !s2_valid_reg || ready;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;
    assign valid    = s2_valid_reg;
    assign data     = s2_data_reg;

    always_comb
    begin
        hi = (red_in > green_in) ? red_in : green_in;
        if (blue_in > hi)
        begin
            hi = blue_in;
        end
        lo = (red_in < green_in) ? red_in : green_in;
        if (blue_in < lo)
        begin
            lo = blue_in;
        end
        if (hi == red_in)
        begin
            opa          = green_in;
            opb          = blue_in;
            s1_base_next = rth_pkg::HUE_BASE_RED;
        end
        else if (hi == green_in)
        begin
            opa          = blue_in;
            opb          = red_in;
            s1_base_next = rth_pkg::HUE_BASE_GREEN;
        end
        else
        begin
            opa          = red_in;
            opb          = green_in;
            s1_base_next = rth_pkg::HUE_BASE_BLUE;
        end
        s1_neg_next   = opa < opb;
        s1_mag_next   = s1_neg_next ? (opb - opa) : (opa - opb);
        s1_value_next = hi;
        s1_span_next  = hi - lo;
        s1_grey_next  = hi == lo;
    end

    always_comb
    begin
        s2_data_next.sat.acc     = rth_pkg::ACC_W'(s1_span_reg) * rth_pkg::ACC_W'(rth_pkg::SAT_SCALE);
        s2_data_next.sat.divisor = s1_value_reg;
        s2_data_next.hue.acc     = rth_pkg::ACC_W'(s1_mag_reg) * rth_pkg::ACC_W'(rth_pkg::HUE_SCALE);
        s2_data_next.hue.divisor = s1_span_reg;
        s2_data_next.side.value  = s1_value_reg;
        s2_data_next.side.base   = s1_base_reg;
        s2_data_next.side.neg    = s1_neg_reg;
        s2_data_next.side.grey   = s1_grey_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_value_reg <= s1_value_next;
            s1_span_reg  <= s1_span_next;
            s1_mag_reg   <= s1_mag_next;
            s1_base_reg  <= s1_base_next;
            s1_neg_reg   <= s1_neg_next;
            s1_grey_reg  <= s1_grey_next;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

endmodule

// ----- rtl/rth_div_cell.sv -----
// One cell of the division chain: develops one quotient bit for saturation and for hue.
// Depends on rth_pkg.
module rth_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rth_pkg::rth_cell_t in_data,
    output logic               valid,
    output rth_pkg::rth_cell_t data,
    input  logic               ready
);

    logic               valid_reg;
    rth_pkg::rth_cell_t data_reg;
    rth_pkg::rth_cell_t data_next;
    logic               load;

    assign load     = !valid_reg || ready;
    assign in_ready = load;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_comb
    begin
        data_next.sat  = rth_pkg::rth_div_step(in_data.sat);
        data_next.hue  = rth_pkg::rth_div_step(in_data.hue);
        data_next.side = in_data.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/rth_finish.sv -----
// Output stage: applies the hue base and sign, forces grey and black pixels, holds the result.
// Depends on rth_pkg.
module rth_finish (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rth_pkg::rth_cell_t        in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [rth_pkg::PIX_W-1:0] hue_out,
    output logic [rth_pkg::PIX_W-1:0] saturation_out,
    output logic [rth_pkg::PIX_W-1:0] value_out
);

    logic                      valid_reg;
    logic [rth_pkg::PIX_W-1:0] hue_reg;
    logic [rth_pkg::PIX_W-1:0] sat_reg;
    logic [rth_pkg::PIX_W-1:0] value_reg;
    logic [rth_pkg::PIX_W-1:0] hue_next;
    logic [rth_pkg::PIX_W-1:0] sat_next;
    logic [rth_pkg::PIX_W-1:0] offset;
    logic                      load;

    assign load           = !valid_reg || out_ready;
    assign in_ready       = load;
    assign out_valid      = valid_reg;
    assign hue_out        = hue_reg;
    assign saturation_out = sat_reg;
    assign value_out      = value_reg;

    always_comb
    begin
        offset = in_data.side.neg ? (~in_data.hue.acc[rth_pkg::PIX_W-1:0] + 1'b1)
                                  : in_data.hue.acc[rth_pkg::PIX_W-1:0];
        if (in_data.side.grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = in_data.side.base + offset;
            sat_next = in_data.sat.acc[rth_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= in_data.side.value;
        end
    end

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for rgb_to_hsv_convert: a queue-fed driver, a random output stall and a
// monitor that predicts each HSV result and compares it with what the block returns.
// Depends on rth_pkg and rgb_to_hsv_convert from the rtl folder.
module tb;

    localparam int RANDOM_PIXELS = 800;
    localparam int QUIET_LIMIT   = 500;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;

    typedef enum int unsigned
    {
        PACE_FULL,
        PACE_RANDOM,
        PACE_LIGHT
    } pace_t;

    typedef struct
    {
        logic [rth_pkg::PIX_W-1:0] red;
        logic [rth_pkg::PIX_W-1:0] green;
        logic [rth_pkg::PIX_W-1:0] blue;
        int unsigned               gap;
    } pixel_t;

    typedef struct packed
    {
        logic [rth_pkg::PIX_W-1:0] hue;
        logic [rth_pkg::PIX_W-1:0] sat;
        logic [rth_pkg::PIX_W-1:0] val;
    } hsv_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [rth_pkg::PIX_W-1:0] red_in = '0;
    logic [rth_pkg::PIX_W-1:0] green_in = '0;
    logic [rth_pkg::PIX_W-1:0] blue_in = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [rth_pkg::PIX_W-1:0] hue_out;
    logic [rth_pkg::PIX_W-1:0] saturation_out;
    logic [rth_pkg::PIX_W-1:0] value_out;

    pixel_t pixel_q[$];
    hsv_t   hsv_expect_q[$];
    pace_t  send_pace = PACE_FULL;
    pace_t  stall_pace = PACE_FULL;
    int     send_wait = 0;
    int     stall_wait = 0;
    int     next_stall = 0;
    int     idle_cycles = 0;
    int     error_count = 0;
    int     pixels_sent = 0;
    int     results_checked = 0;
    int     black_count = 0;
    int     grey_count = 0;
    hsv_t   seen;
    hsv_t   wanted;

    rgb_to_hsv_convert dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .red_in         (red_in),
        .green_in       (green_in),
        .blue_in        (blue_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hue_out        (hue_out),
        .saturation_out (saturation_out),
        .value_out      (value_out)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic hsv_t rgb_to_hsv_predict(input logic [rth_pkg::PIX_W-1:0] r,
                                                input logic [rth_pkg::PIX_W-1:0] g,
                                                input logic [rth_pkg::PIX_W-1:0] b);
        hsv_t res;
        int   rv;
        int   gv;
        int   bv;
        int   hi;
        int   lo;
        int   span;
        int   sat;
        int   base;
        int   diff;
        int   step;
        int   hue;
        rv = int'(r);
        gv = int'(g);
        bv = int'(b);
        hi = (rv > gv) ? rv : gv;
        hi = (bv > hi) ? bv : hi;
        lo = (rv < gv) ? rv : gv;
        lo = (bv < lo) ? bv : lo;
        res = '0;
        res.val = hi[rth_pkg::PIX_W-1:0];
        if (hi != 0)
        begin
            span = hi - lo;
            sat = (int'(rth_pkg::SAT_SCALE) * span) / hi;
            res.sat = sat[rth_pkg::PIX_W-1:0];
            if (sat != 0)
            begin
                if (hi == rv)
                begin
                    base = int'(rth_pkg::HUE_BASE_RED);
                    diff = gv - bv;
                end
                else if (hi == gv)
                begin
                    base = int'(rth_pkg::HUE_BASE_GREEN);
                    diff = bv - rv;
                end
                else
                begin
                    base = int'(rth_pkg::HUE_BASE_BLUE);
                    diff = rv - gv;
                end
                step = ((diff < 0 ? -diff : diff) * int'(rth_pkg::HUE_SCALE)) / span;
                hue = (diff < 0) ? base - step : base + step;
                res.hue = hue[rth_pkg::PIX_W-1:0];
            end
        end
        return res;
    endfunction

    function automatic int draw_wait(input pace_t pace);
        case (pace)
            PACE_RANDOM: return $urandom_range(0, 18);
            PACE_LIGHT:  return $urandom_range(0, 2);
            default:     return 0;
        endcase
    endfunction

    task automatic add_pixel(input int r, input int g, input int b);
        pixel_t px;
        if (pixel_q.size() % 40 == 0)
        begin
            send_pace = pace_t'($urandom_range(0, 2));
        end
        px.red = r[rth_pkg::PIX_W-1:0];
        px.green = g[rth_pkg::PIX_W-1:0];
        px.blue = b[rth_pkg::PIX_W-1:0];
        px.gap = draw_wait(send_pace);
        pixel_q.push_back(px);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_wait <= 0;
        end
        else if (in_valid)
        begin
            if (in_ready)
            begin
                void'(pixel_q.pop_front());
                if (pixel_q.size() != 0 && pixel_q[0].gap == 0)
                begin
                    red_in <= pixel_q[0].red;
                    green_in <= pixel_q[0].green;
                    blue_in <= pixel_q[0].blue;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (pixel_q.size() != 0)
                    begin
                        send_wait <= pixel_q[0].gap - 1;
                    end
                end
            end
        end
        else if (pixel_q.size() != 0)
        begin
            if (send_wait == 0)
            begin
                in_valid <= 1'b1;
                red_in <= pixel_q[0].red;
                green_in <= pixel_q[0].green;
                blue_in <= pixel_q[0].blue;
            end
            else
            begin
                send_wait <= send_wait - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                stall_pace <= pace_t'($urandom_range(0, 2));
            end
            next_stall = draw_wait(stall_pace);
            if (next_stall != 0)
            begin
                out_ready <= 1'b0;
                stall_wait <= next_stall - 1;
            end
        end
        else if (stall_wait != 0)
        begin
            stall_wait <= stall_wait - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = '{hue: hue_out, sat: saturation_out, val: value_out};
                results_checked++;
                if (hsv_expect_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("tb: result with nothing pending: h=%0d s=%0d v=%0d",
                                 seen.hue, seen.sat, seen.val);
                    end
                end
                else
                begin
                    wanted = hsv_expect_q.pop_front();
                    if (seen !== wanted)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                        begin
                            $display("tb: mismatch: h=%0d/%0d s=%0d/%0d v=%0d/%0d (expected/actual)",
                                     wanted.hue, seen.hue, wanted.sat, seen.sat,
                                     wanted.val, seen.val);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                wanted = rgb_to_hsv_predict(red_in, green_in, blue_in);
                hsv_expect_q.push_back(wanted);
                pixels_sent++;
                if (wanted.val == 0)
                begin
                    black_count++;
                end
                else if (wanted.sat == 0)
                begin
                    grey_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= QUIET_LIMIT)
        begin
            $display("tb: stopped after %0d quiet cycles: %0d pixels sent, %0d results compared",
                     QUIET_LIMIT, pixels_sent, results_checked);
            $display("tb: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int i;
        int kind;
        int a;
        int b;
        int c;
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(1, 1, 1);
        add_pixel(128, 128, 128);
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 255, 0);
        add_pixel(255, 0, 255);
        add_pixel(0, 255, 255);
        add_pixel(255, 0, 1);
        add_pixel(255, 1, 0);
        add_pixel(255, 254, 254);
        add_pixel(1, 0, 0);
        add_pixel(0, 1, 0);
        add_pixel(0, 0, 1);
        add_pixel(0, 255, 1);
        add_pixel(1, 255, 0);
        add_pixel(254, 0, 255);
        add_pixel(0, 1, 255);
        add_pixel(8'hAA, 8'h55, 8'hFF);
        add_pixel(8'h55, 8'hAA, 8'h00);
        add_pixel(8'h80, 8'h7F, 8'h01);
        for (i = 0; i < RANDOM_PIXELS; i++)
        begin
            kind = $urandom_range(0, 19);
            a = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
            c = $urandom_range(0, 255);
            if (kind < 10)
            begin
                add_pixel(a, b, c);
            end
            else if (kind < 13)
            begin
                c = c & a;
                case ($urandom_range(0, 2))
                    0:       add_pixel(a, a, c);
                    1:       add_pixel(a, c, a);
                    default: add_pixel(c, a, a);
                endcase
            end
            else if (kind < 15)
            begin
                add_pixel(a, a, a);
            end
            else if (kind < 17)
            begin
                add_pixel($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
            end
            else
            begin
                add_pixel(a[0] ? $urandom_range(250, 255) : $urandom_range(0, 5),
                          b[0] ? $urandom_range(250, 255) : $urandom_range(0, 5),
                          c[0] ? $urandom_range(250, 255) : $urandom_range(0, 5));
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pixel_q.size() != 0 || in_valid)
        begin
            @(negedge clk);
        end
        while (hsv_expect_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d pixels converted, %0d results compared (%0d black, %0d grey)",
                 pixels_sent, results_checked, black_count, grey_count);
        $display("tb: %0d mismatched or unexpected results", error_count);
        if (error_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
